[rtl/tki_pkg.sv]
// Package for the top-k ranked insertion buffer.
// Holds sizes, register indexes, payload structs and the float ordering functions.
// No dependencies.
`default_nettype none

package tki_pkg;

    localparam int MAX_KEEP  = 32;
    localparam int KEEP_W    = 6;   // holds 0..MAX_KEEP
    localparam int IDX_W     = 5;   // indexes 0..MAX_KEEP-1
    localparam int MAX_GEN   = 64;
    localparam int GEN_W     = 7;   // holds 0..MAX_GEN
    localparam int TAG_BITS  = 16;
    localparam int FIT_W     = 32;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [KEEP_W-1:0] NOT_KEPT = KEEP_W'(MAX_KEEP);

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_MAXIMIZE = 2'd0;
    localparam logic [1:0] REG_GEN_SIZE = 2'd1;
    localparam logic [1:0] REG_KEEP     = 2'd2;

    localparam logic             RST_MAXIMIZE = 1'b0;
    localparam logic [GEN_W-1:0] RST_GEN_SIZE = GEN_W'(8);
    localparam logic [KEEP_W-1:0] RST_KEEP    = KEEP_W'(4);

    typedef struct packed {
        logic [FIT_W-1:0]    fitness_bits;
        logic [TAG_BITS-1:0] candidate_tag;
    } t_in_word;

    typedef struct packed {
        logic                rejected;
        logic [KEEP_W-1:0]   insert_rank;
        logic [FIT_W-1:0]    best_so_far;
        logic                generation_done;
        logic [IDX_W-1:0]    entry_rank;
        logic [FIT_W-1:0]    entry_fitness;
        logic [TAG_BITS-1:0] entry_tag;
        logic                last;
    } t_out_word;

    typedef struct packed {
        logic             maximize;
        logic [GEN_W-1:0] generation_size;
        logic [KEEP_W-1:0] keep_count;
    } t_cfg;

    // One classified word waiting in the queue.
    typedef struct packed {
        logic                reject;
        logic [FIT_W-1:0]    fitness;
        logic [TAG_BITS-1:0] tag;
    } t_qword;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_qword word;
    } t_qhead;

    // Maps float bits to an unsigned key whose order matches the float order.
    // Both zeros map to the same key.
    function automatic logic [FIT_W-1:0] order_key(input logic [FIT_W-1:0] b);
        logic [FIT_W-1:0] v;
        v = (b[FIT_W-2:0] == '0) ? '0 : b;
        return v[FIT_W-1] ? ~v : (v | {1'b1, {(FIT_W-1){1'b0}}});
    endfunction

    function automatic logic beats(input logic [FIT_W-1:0] a, input logic [FIT_W-1:0] b,
                                   input logic maximize);
        logic [FIT_W-1:0] ka;
        logic [FIT_W-1:0] kb;
        ka = order_key(a);
        kb = order_key(b);
        return maximize ? (ka > kb) : (ka < kb);
    endfunction

    function automatic logic non_finite(input logic [FIT_W-1:0] b);
        return b[30:23] == 8'hFF;
    endfunction

endpackage

`default_nettype wire

[rtl/top_k_ranked_insert.sv]
// Top-k ranked insertion buffer: an accepted word goes through the four-deep queue and the output
// register to give a single result; a word that completes a generation gives its list entries from
// the updated table instead, one entry per cycle while the output is free. Words are taken one per
// cycle while the queue has room; the back end inserts one word per cycle, while its output is free
// and no list drains, through parallel compare-and-shift. Reset is synchronous, active low, and
// restores config, pointers, counters and state at once; the table needs no clearing pass.
`default_nettype none

module top_k_ranked_insert (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Input channel: one scored candidate per word.
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  tki_pkg::t_in_word            i_in_word,
    // Output channel: one result per word.
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output tki_pkg::t_out_word           o_out_word,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tki_pkg::ADDR_W-1:0]    paddr,
    input  wire [tki_pkg::DATA_W-1:0]    pwdata,
    output logic [tki_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int DW = tki_pkg::DATA_W;

    // Configuration registers. The user is to change them only while the block is idle (the
    // block does not enforce it), since the back end reads them directly.
    tki_pkg::t_cfg        r_cfg;
    tki_pkg::t_qhead      head;
    logic                 pop;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.maximize        <= tki_pkg::RST_MAXIMIZE;
            r_cfg.generation_size <= tki_pkg::RST_GEN_SIZE;
            r_cfg.keep_count      <= tki_pkg::RST_KEEP;
        end else if (wr_en) begin
            unique case (reg_idx)
                tki_pkg::REG_MAXIMIZE: r_cfg.maximize        <= pwdata[0];
                tki_pkg::REG_GEN_SIZE: r_cfg.generation_size <= pwdata[tki_pkg::GEN_W-1:0];
                tki_pkg::REG_KEEP:     r_cfg.keep_count      <= pwdata[tki_pkg::KEEP_W-1:0];
                default: begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tki_pkg::REG_MAXIMIZE: prdata = DW'(r_cfg.maximize);
            tki_pkg::REG_GEN_SIZE: prdata = DW'(r_cfg.generation_size);
            tki_pkg::REG_KEEP:     prdata = DW'(r_cfg.keep_count);
            default:               prdata = '0;
        endcase
    end

    // The front end classifies each word and queues it, so input acceptance
    // continues, while the queue has room, as the back end drains a generation's list.
    tki_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    // The back end owns the ranked table and the output register.
    tki_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[rtl/tki_front.sv]
// Front end of the top-k buffer: accepts input words, flags non-finite fitness
// and queues the classified words for the back end. Depends on tki_pkg.
`default_nettype none

module tki_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tki_pkg::t_in_word    i_in_word,
    output tki_pkg::t_qhead      o_head,
    input  wire                  i_pop
);

    localparam int QD = tki_pkg::Q_DEPTH;

    tki_pkg::t_qword                 r_mem [QD];
    logic [tki_pkg::Q_PTR_W-1:0]     r_wr;
    logic [tki_pkg::Q_PTR_W-1:0]     r_rd;
    logic [tki_pkg::Q_CNT_W-1:0]     r_count;
    logic                            push;
    logic                            pop;
    tki_pkg::t_qword                 wr_word;

    assign o_in_ready = (r_count != tki_pkg::Q_CNT_W'(QD));
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_count != '0);

    always_comb begin
        wr_word.reject  = tki_pkg::non_finite(i_in_word.fitness_bits);
        wr_word.fitness = i_in_word.fitness_bits;
        wr_word.tag     = i_in_word.candidate_tag;
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tki_back.sv]
// Back end of the top-k buffer: ranked table with parallel compare-and-shift,
// generation bookkeeping, list drain and the output register. Depends on tki_pkg.
`default_nettype none

module tki_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tki_pkg::t_cfg        i_cfg,
    input  tki_pkg::t_qhead      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tki_pkg::t_out_word   o_out_word
);

    localparam int NK = tki_pkg::MAX_KEEP;
    localparam int KW = tki_pkg::KEEP_W;
    localparam int IW = tki_pkg::IDX_W;
    localparam int GW = tki_pkg::GEN_W;
    localparam int FW = tki_pkg::FIT_W;
    localparam int TW = tki_pkg::TAG_BITS;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [FW-1:0]  r_key [NK];
    logic [TW-1:0]  r_tag [NK];
    logic [FW-1:0]  n_key [NK];
    logic [TW-1:0]  n_tag [NK];
    logic [KW-1:0]  r_filled;
    logic [GW-1:0]  r_offspring;
    logic [FW-1:0]  r_best;
    logic           r_state;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_last_idx;
    logic [KW-1:0]  r_rank;
    logic           r_out_valid;
    tki_pkg::t_out_word r_out;

    logic [KW-1:0]  keep_eff;
    logic [GW-1:0]  gen_eff;
    logic [KW-1:0]  filled_eff;
    logic [NK-1:0]  beat;
    logic [KW-1:0]  pos;
    logic           inserted;
    logic [KW-1:0]  top;
    logic [KW-1:0]  n_filled;
    logic [GW-1:0]  off_next;
    logic           gen_done;
    logic [FW-1:0]  n_best;
    logic [KW-1:0]  rank;
    logic           out_free;
    logic           out_load;
    logic           pop_item;
    logic [FW-1:0]  f;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = (r_state == ST_RUN) && i_head.valid && out_free;
    assign pop_item = o_pop && !i_head.word.reject;
    assign f        = i_head.word.fitness;

    // The output register takes a new word on a plain result or a list entry.
    assign out_load = (o_pop && (i_head.word.reject || !gen_done)) ||
                      ((r_state == ST_DRAIN) && out_free);

    always_comb begin
        if (i_cfg.keep_count == '0) begin
            keep_eff = KW'(1);
        end else if (i_cfg.keep_count > KW'(NK)) begin
            keep_eff = KW'(NK);
        end else begin
            keep_eff = i_cfg.keep_count;
        end
        if (i_cfg.generation_size == '0) begin
            gen_eff = GW'(1);
        end else if (i_cfg.generation_size > GW'(tki_pkg::MAX_GEN)) begin
            gen_eff = GW'(tki_pkg::MAX_GEN);
        end else begin
            gen_eff = i_cfg.generation_size;
        end
    end

    // A new generation starts with an empty table.
    always_comb begin
        if (r_offspring == '0) begin
            filled_eff = '0;
        end else if (r_filled < keep_eff) begin
            filled_eff = r_filled;
        end else begin
            filled_eff = keep_eff;
        end
    end

    // Every kept entry compares against the new fitness at once.
    always_comb begin
        for (int j = 0; j < NK; j++) begin
            beat[j] = (KW'(j) < filled_eff) && tki_pkg::beats(f, r_key[j], i_cfg.maximize);
        end
    end

    // First entry that the new fitness strictly beats, else the end of the list.
    always_comb begin
        pos = filled_eff;
        for (int j = NK - 1; j >= 0; j--) begin
            if (beat[j]) begin
                pos = KW'(j);
            end
        end
    end

    always_comb begin
        inserted = pos < keep_eff;
        top      = (filled_eff < keep_eff) ? filled_eff : keep_eff - 1'b1;
        n_filled = (inserted && filled_eff < keep_eff) ? filled_eff + 1'b1 : filled_eff;
        rank     = inserted ? pos : tki_pkg::NOT_KEPT;
        off_next = r_offspring + 1'b1;
        gen_done = off_next >= gen_eff;
        n_best   = tki_pkg::beats(f, r_best, i_cfg.maximize) ? f : r_best;
    end

    // Entries from the insert point up to the top move down by one.
    always_comb begin
        for (int j = 0; j < NK; j++) begin
            n_key[j] = r_key[j];
            n_tag[j] = r_tag[j];
        end
        for (int j = 1; j < NK; j++) begin
            if (inserted && KW'(j) > pos && KW'(j) <= top) begin
                n_key[j] = r_key[j-1];
                n_tag[j] = r_tag[j-1];
            end
        end
        if (inserted) begin
            n_key[pos[IW-1:0]] = f;
            n_tag[pos[IW-1:0]] = i_head.word.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_item) begin
            for (int j = 0; j < NK; j++) begin
                r_key[j] <= n_key[j];
                r_tag[j] <= n_tag[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_offspring <= '0;
            r_best      <= '0;
            r_state     <= ST_RUN;
            r_idx       <= '0;
            r_last_idx  <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (o_pop && i_head.word.reject) begin
                        r_out.rejected        <= 1'b1;
                        r_out.insert_rank     <= tki_pkg::NOT_KEPT;
                        r_out.best_so_far     <= r_best;
                        r_out.generation_done <= 1'b0;
                        r_out.entry_rank      <= '0;
                        r_out.entry_fitness   <= '0;
                        r_out.entry_tag       <= '0;
                        r_out.last            <= 1'b1;
                    end else if (pop_item) begin
                        r_filled <= n_filled;
                        r_best   <= n_best;
                        if (gen_done) begin
                            // The list then leaves from the updated table in the drain state.
                            r_offspring <= '0;
                            r_state     <= ST_DRAIN;
                            r_idx       <= '0;
                            r_last_idx  <= IW'(n_filled - 1'b1);
                            r_rank      <= rank;
                        end else begin
                            r_offspring           <= off_next;
                            r_out.rejected        <= 1'b0;
                            r_out.insert_rank     <= rank;
                            r_out.best_so_far     <= n_best;
                            r_out.generation_done <= 1'b0;
                            r_out.entry_rank      <= '0;
                            r_out.entry_fitness   <= '0;
                            r_out.entry_tag       <= '0;
                            r_out.last            <= 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        r_out.rejected        <= 1'b0;
                        r_out.insert_rank     <= r_rank;
                        r_out.best_so_far     <= r_best;
                        r_out.generation_done <= 1'b1;
                        r_out.entry_rank      <= r_idx;
                        r_out.entry_fitness   <= r_key[r_idx];
                        r_out.entry_tag       <= r_tag[r_idx];
                        r_out.last            <= (r_idx == r_last_idx);
                        if (r_idx == r_last_idx) begin
                            r_state <= ST_RUN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

[sim/top_k_ranked_insert_tb.sv]
// Self-checking testbench for top_k_ranked_insert: random and directed candidate words
// are checked against an in-bench model of the ranked table.
// Depends on rtl/tki_pkg.sv, rtl/top_k_ranked_insert.sv, rtl/tki_front.sv and rtl/tki_back.sv.
`timescale 1ns / 1ps

module top_k_ranked_insert_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_WORDS = 150;
    localparam int FW = tki_pkg::FIT_W;
    localparam logic [FW-1:0] POS_INF = 32'h7F80_0000;
    localparam logic [FW-1:0] NEG_INF = 32'hFF80_0000;

    // Clock, reset and the two data channels.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tki_pkg::t_in_word in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tki_pkg::t_out_word out_word;

    // Configuration port; pready is always high on this block.
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [tki_pkg::ADDR_W-1:0] paddr = '0;
    logic [tki_pkg::DATA_W-1:0] pwdata = '0;
    logic [tki_pkg::DATA_W-1:0] prdata;
    logic pready;

    // Words waiting to be offered, and results the block still owes.
    tki_pkg::t_in_word candidate_backlog[$];
    tki_pkg::t_out_word awaited_results[$];

    // Shadow copy of the registers, written only while the block is idle.
    logic shadow_max = tki_pkg::RST_MAXIMIZE;
    logic [tki_pkg::GEN_W-1:0] shadow_gen = tki_pkg::RST_GEN_SIZE;
    logic [tki_pkg::KEEP_W-1:0] shadow_keep = tki_pkg::RST_KEEP;

    // Model of the ranked table, its fill level, the generation count and the
    // running best. The best starts at +0.0.
    logic [FW-1:0] kept_fit [tki_pkg::MAX_KEEP];
    logic [tki_pkg::TAG_BITS-1:0] kept_tag [tki_pkg::MAX_KEEP];
    int kept_n = 0;
    int gen_taken = 0;
    logic [FW-1:0] best_fit = '0;

    int fault_count = 0;
    int accepted_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit no_gaps = 1'b0;

    logic [FW-1:0] opening_fits [18];

    top_k_ranked_insert DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Maps float bits onto an unsigned scale that follows the numeric order.
    // Both zeros land on the midpoint, so +0 and -0 compare equal.
    function automatic logic [FW-1:0] fit_order(input logic [FW-1:0] b);
        if (b[FW-2:0] == '0) begin
            return 32'h8000_0000;
        end
        return b[FW-1] ? ~b : {1'b1, b[FW-2:0]};
    endfunction

    // True when a is strictly better than b under the current mode.
    function automatic logic outranks(input logic [FW-1:0] a, input logic [FW-1:0] b);
        logic [FW-1:0] ka;
        logic [FW-1:0] kb;
        ka = fit_order(a);
        kb = fit_order(b);
        return shadow_max ? (ka > kb) : (ka < kb);
    endfunction

    // Applies one accepted candidate to the table model and queues the results
    // it should produce.
    task automatic rank_candidate(input tki_pkg::t_in_word w);
        tki_pkg::t_out_word r;
        int keep;
        int gen_lim;
        int filled;
        int pos;
        int top;
        int j;
        r = '0;
        r.last = 1'b1;
        r.best_so_far = best_fit;
        // NaN and infinity are flagged and leave every piece of state alone.
        if (w.fitness_bits[30:23] == 8'hFF) begin
            r.rejected = 1'b1;
            r.insert_rank = tki_pkg::NOT_KEPT;
            awaited_results.push_back(r);
            return;
        end
        // The first candidate of a generation starts from an empty table.
        if (gen_taken == 0) begin
            for (j = 0; j < tki_pkg::MAX_KEEP; j++) begin
                kept_fit[j] = shadow_max ? NEG_INF : POS_INF;
                kept_tag[j] = '0;
            end
            kept_n = 0;
        end
        keep = (shadow_keep == 0) ? 1 :
               ((shadow_keep > tki_pkg::MAX_KEEP) ? tki_pkg::MAX_KEEP : shadow_keep);
        gen_lim = (shadow_gen == 0) ? 1 :
                  ((shadow_gen > tki_pkg::MAX_GEN) ? tki_pkg::MAX_GEN : shadow_gen);
        // A smaller keep count drops the entries beyond it.
        filled = (kept_n < keep) ? kept_n : keep;
        // Ties stay behind the entries that arrived earlier.
        pos = filled;
        for (j = 0; j < filled; j++) begin
            if (pos == filled && outranks(w.fitness_bits, kept_fit[j])) begin
                pos = j;
            end
        end
        if (pos < keep) begin
            top = (filled < keep) ? filled : keep - 1;
            for (j = top; j > pos; j--) begin
                kept_fit[j] = kept_fit[j-1];
                kept_tag[j] = kept_tag[j-1];
            end
            kept_fit[pos] = w.fitness_bits;
            kept_tag[pos] = w.candidate_tag;
            if (filled < keep) begin
                filled++;
            end
            r.insert_rank = tki_pkg::KEEP_W'(pos);
        end else begin
            r.insert_rank = tki_pkg::NOT_KEPT;
        end
        kept_n = filled;
        gen_taken++;
        if (outranks(w.fitness_bits, best_fit)) begin
            best_fit = w.fitness_bits;
        end
        r.best_so_far = best_fit;
        if (gen_taken >= gen_lim) begin
            // Generation end: list the table best first, last flag on the final entry.
            gen_taken = 0;
            r.generation_done = 1'b1;
            for (j = 0; j < filled; j++) begin
                r.entry_rank = tki_pkg::IDX_W'(j);
                r.entry_fitness = kept_fit[j];
                r.entry_tag = kept_tag[j];
                r.last = (j + 1 == filled);
                awaited_results.push_back(r);
            end
        end else begin
            awaited_results.push_back(r);
        end
    endtask

    task automatic log_fault(input string what, input tki_pkg::t_out_word want,
                             input tki_pkg::t_out_word got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  expected rej=%b rank=%0d best=%h done=%b erank=%0d efit=%h etag=%h last=%b",
                     want.rejected, want.insert_rank, want.best_so_far, want.generation_done,
                     want.entry_rank, want.entry_fitness, want.entry_tag, want.last);
            $display("  actual   rej=%b rank=%0d best=%h done=%b erank=%0d efit=%h etag=%h last=%b",
                     got.rejected, got.insert_rank, got.best_so_far, got.generation_done,
                     got.entry_rank, got.entry_fitness, got.entry_tag, got.last);
        end
    endtask

    // Compares one result word with the oldest expectation, field by field.
    task automatic check_result(input tki_pkg::t_out_word got);
        tki_pkg::t_out_word want;
        if (awaited_results.size() == 0) begin
            log_fault("unexpected result word", '0, got);
            return;
        end
        want = awaited_results.pop_front();
        if (got.rejected !== want.rejected || got.insert_rank !== want.insert_rank ||
            got.best_so_far !== want.best_so_far ||
            got.generation_done !== want.generation_done ||
            got.entry_rank !== want.entry_rank || got.entry_fitness !== want.entry_fitness ||
            got.entry_tag !== want.entry_tag || got.last !== want.last) begin
            log_fault("result word mismatch", want, got);
        end
    endtask

    // Sender: predicts each word as it is accepted, then offers the next one from
    // the backlog unless this cycle is chosen as a gap. A word that is waiting
    // keeps valid and payload steady until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                rank_candidate(in_word);
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || in_ready) begin
                if (candidate_backlog.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= 21)) begin
                    in_valid <= 1'b1;
                    in_word <= candidate_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result word and drives ready. Once enough
    // words have gone in, it holds ready low for a long stretch so the queue
    // inside the block fills and input ready drops while the sender keeps going.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                check_result(out_word);
            end
            if (!hold_done && accepted_count >= HOLD_AFTER_WORDS) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL top_k_ranked_insert");
            $finish;
        end
    end

    // One register write: setup cycle, then the access cycle whose closing edge
    // performs the write. The shadow copy follows at that edge.
    task automatic write_reg(input logic [1:0] idx, input logic [tki_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tki_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tki_pkg::REG_MAXIMIZE: begin
                shadow_max = val[0];
            end
            tki_pkg::REG_GEN_SIZE: begin
                shadow_gen = val[tki_pkg::GEN_W-1:0];
            end
            tki_pkg::REG_KEEP: begin
                shadow_keep = val[tki_pkg::KEEP_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic write_all(input logic mx, input int gen, input int keep);
        write_reg(tki_pkg::REG_MAXIMIZE, tki_pkg::DATA_W'(mx));
        write_reg(tki_pkg::REG_GEN_SIZE, tki_pkg::DATA_W'(gen));
        write_reg(tki_pkg::REG_KEEP, tki_pkg::DATA_W'(keep));
    endtask

    // Fitness mix: corner values, a small pool that produces ties, and raw bits.
    function automatic logic [FW-1:0] pick_fitness();
        logic [FW-1:0] corners [11];
        corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
                    32'h7F7F_FFFF, 32'hFF7F_FFFF, POS_INF, NEG_INF,
                    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h007F_FFFF};
        case ($urandom_range(0, 9))
            0: begin
                return corners[$urandom_range(0, 10)];
            end
            1, 2, 3: begin
                return {1'($urandom_range(0, 1)),
                        31'h3F80_0000 + 31'($urandom_range(0, 3) << 20)};
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Queues n random words. Called between clock edges so the sender sees a
    // consistent backlog.
    task automatic queue_random(input int n);
        tki_pkg::t_in_word w;
        repeat (n) begin
            w.fitness_bits = pick_fitness();
            w.candidate_tag = tki_pkg::TAG_BITS'($urandom_range(0, 65535));
            candidate_backlog.push_back(w);
        end
    endtask

    // Waits until every word has gone in and every result has come back, then
    // lets the pipeline settle before anything else changes.
    task automatic wait_idle();
        @(negedge i_clk);
        while (candidate_backlog.size() != 0 || in_valid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        tki_pkg::t_in_word w;
        int i;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening under the reset settings (minimize, eight per
        // generation, four kept): both zeros as a tie, both infinities and quiet NaNs of
        // either sign, the largest finite magnitudes, denormals and repeated values.
        // The twelfth word completes a generation; the last few start another
        // one that the next settings cut short.
        opening_fits = '{32'h0000_0000, 32'h8000_0000, POS_INF, NEG_INF, 32'h7FC0_0000,
                         32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000,
                         32'h3F80_0000, 32'h0000_0001, 32'h8000_0001, 32'hBF80_0000,
                         32'hBF80_0000, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000,
                         32'h5555_AAAA};
        for (i = 0; i < 18; i++) begin
            w.fitness_bits = opening_fits[i];
            w.candidate_tag = i[0] ? 16'hFFFF : 16'h0000;
            candidate_backlog.push_back(w);
        end
        wait_idle();

        // Largest mode, every word is its own generation with one entry kept.
        // The generation left open above ends on the first word.
        write_all(1'b1, 1, 1);
        @(negedge i_clk);
        queue_random(20);
        wait_idle();

        // Biggest legal table and generation, run without any gaps. The phase
        // stops a few words into the second generation.
        write_all(1'b0, tki_pkg::MAX_GEN, tki_pkg::MAX_KEEP);
        no_gaps = 1'b1;
        @(negedge i_clk);
        queue_random(70);
        wait_idle();
        no_gaps = 1'b0;

        // Flip the mode in the middle of a generation; kept entries stay.
        write_reg(tki_pkg::REG_MAXIMIZE, tki_pkg::DATA_W'(1));
        @(negedge i_clk);
        queue_random(30);
        wait_idle();

        // Shrink the table and the generation below what is already taken: the
        // next word ends the generation and the extra entries drop out. The
        // long receiver hold lands in this phase.
        write_reg(tki_pkg::REG_KEEP, tki_pkg::DATA_W'(3));
        write_reg(tki_pkg::REG_GEN_SIZE, tki_pkg::DATA_W'(5));
        @(negedge i_clk);
        queue_random(40);
        wait_idle();

        // Zero in both sizes behaves as one.
        write_all(1'b0, 0, 0);
        @(negedge i_clk);
        queue_random(15);
        wait_idle();

        // All ones in both sizes saturate at the maximum.
        write_all(1'b0, 127, 63);
        @(negedge i_clk);
        queue_random(70);
        wait_idle();

        // A few small random settings.
        repeat (3) begin
            write_all(1'($urandom_range(0, 1)), $urandom_range(1, 12), $urandom_range(1, 8));
            @(negedge i_clk);
            queue_random(20);
            wait_idle();
        end

        if (awaited_results.size() != 0) begin
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("PASS top_k_ranked_insert");
        end else begin
            $display("FAIL top_k_ranked_insert");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tki_pkg.sv
rtl/tki_front.sv
rtl/tki_back.sv
rtl/top_k_ranked_insert.sv
sim/top_k_ranked_insert_tb.sv
